@@ rtl/swmf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the sliding window median filter.
// Used by every module of the block; depends on nothing.
package swmf_pkg;

    localparam int DATA_W             = 16;
    localparam int CFG_W              = 5;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;
    localparam int WINDOW_MAX_DEFAULT = 16;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 5'd3;

    // Register index, taken from paddr[2] (word address)
    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } swmf_state_t;

    // Sequencer to rank unit: one compare issued this cycle
    typedef struct packed {
        logic issue;
        logic first;
        logic last;
    } swmf_ctl_t;

endpackage
`default_nettype wire

@@ rtl/swmf_hist.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Circular sample history: append with window trim, two registered read ports.
// Depends on swmf_pkg.
module swmf_hist
    import swmf_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
)
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       wr_en,
    input  wire logic signed [DATA_W-1:0]                   wr_data,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0]            win,
    input  wire logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] rd_a_off,
    input  wire logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] rd_b_off,
    output logic signed [DATA_W-1:0]                        rd_a_data,
    output logic signed [DATA_W-1:0]                        rd_b_data,
    output logic [$clog2(WINDOW_MAX+1)-1:0]                 fill
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] WM_S = SUM_W'(WINDOW_MAX);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_MAX - 1);
    localparam logic [CNT_W-1:0] WM_C = CNT_W'(WINDOW_MAX);

    logic signed [DATA_W-1:0] mem [WINDOW_MAX];
    logic signed [DATA_W-1:0] rd_a_data_reg;
    logic signed [DATA_W-1:0] rd_b_data_reg;

    logic [IDX_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    logic             full;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_a_addr;
    logic [IDX_W-1:0] rd_b_addr;
    logic [IDX_W-1:0] oldest_app;
    logic [CNT_W-1:0] fill_app;
    logic [CNT_W-1:0] drop;
    logic [SUM_W-1:0] trim_sum;
    logic [SUM_W-1:0] sum_wr;
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;

    // Offset from the oldest entry, wrapped once into the ring
    function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= WM_S) ? (s - WM_S) : s;
        return r[IDX_W-1:0];
    endfunction

    assign full   = (fill_reg == WM_C);
    assign sum_wr = SUM_W'(oldest_reg) + SUM_W'(fill_reg);
    assign sum_a  = SUM_W'(oldest_reg) + SUM_W'(rd_a_off);
    assign sum_b  = SUM_W'(oldest_reg) + SUM_W'(rd_b_off);
    assign rd_a_addr = wrap(sum_a);
    assign rd_b_addr = wrap(sum_b);

    always_comb
    begin
        if (full)
        begin
            wr_addr    = oldest_reg;
            oldest_app = (oldest_reg == LAST_IDX) ? '0 : oldest_reg + 1'b1;
            fill_app   = fill_reg;
        end
        else
        begin
            wr_addr    = wrap(sum_wr);
            oldest_app = oldest_reg;
            fill_app   = fill_reg + 1'b1;
        end

        // Drop the excess oldest samples in one step
        drop     = fill_app - win;
        trim_sum = SUM_W'(oldest_app) + SUM_W'(drop);

        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        if (wr_en)
        begin
            if (fill_app > win)
            begin
                oldest_next = wrap(trim_sum);
                fill_next   = win;
            end
            else
            begin
                oldest_next = oldest_app;
                fill_next   = fill_app;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data_reg <= mem[rd_a_addr];
        rd_b_data_reg <= mem[rd_b_addr];
    end

    assign rd_a_data = rd_a_data_reg;
    assign rd_b_data = rd_b_data_reg;
    assign fill      = fill_reg;

endmodule
`default_nettype wire

@@ rtl/swmf_rank.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared compare-and-count unit: ranks each candidate against every held sample
// and captures the two middle values. Depends on swmf_pkg.
module swmf_rank
    import swmf_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire swmf_ctl_t                       ctl,
    input  wire logic signed [DATA_W-1:0]        cand,
    input  wire logic signed [DATA_W-1:0]        elem,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0] fill,
    output logic signed [DATA_W-1:0]             median
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    swmf_ctl_t ctl_reg;

    logic [CNT_W-1:0] cnt_lt_reg, cnt_lt_next;
    logic [CNT_W-1:0] cnt_le_reg, cnt_le_next;
    logic signed [DATA_W-1:0] lo_reg, lo_next;
    logic signed [DATA_W-1:0] hi_reg, hi_next;

    logic [CNT_W-1:0] k_lo;
    logic [CNT_W-1:0] k_hi;
    logic             lt;
    logic             le;
    logic [DATA_W:0]  pair_sum;
    logic [DATA_W:0]  pair_adj;

    assign k_hi = fill >> 1;
    assign k_lo = fill[0] ? k_hi : k_hi - 1'b1;

    assign lt = (elem <  cand);
    assign le = (elem <= cand);

    always_comb
    begin
        cnt_lt_next = cnt_lt_reg;
        cnt_le_next = cnt_le_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        if (ctl_reg.issue)
        begin
            cnt_lt_next = (ctl_reg.first ? '0 : cnt_lt_reg) + CNT_W'(lt);
            cnt_le_next = (ctl_reg.first ? '0 : cnt_le_reg) + CNT_W'(le);
            // Candidate holds rank k when lt <= k < le
            if (ctl_reg.last)
            begin
                if ((cnt_lt_next <= k_lo) && (k_lo < cnt_le_next))
                begin
                    lo_next = cand;
                end
                if ((cnt_lt_next <= k_hi) && (k_hi < cnt_le_next))
                begin
                    hi_next = cand;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_lt_reg <= cnt_lt_next;
        cnt_le_reg <= cnt_le_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
    end

    // Mean of the middle pair, truncated toward zero
    assign pair_sum = {lo_reg[DATA_W-1], lo_reg} + {hi_reg[DATA_W-1], hi_reg};
    assign pair_adj = pair_sum + {{DATA_W{1'b0}}, pair_sum[DATA_W]};
    assign median   = fill[0] ? hi_reg : pair_adj[DATA_W:1];

endmodule
`default_nettype wire

@@ rtl/swmf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: walks candidate and element offsets over the held samples,
// then hands the result to the output register. Depends on swmf_pkg.
module swmf_ctrl
    import swmf_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_accept,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0] fill,
    input  wire logic                            out_free,
    output swmf_ctl_t                            ctl,
    output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] cand_off,
    output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] elem_off,
    output logic                                 load_out,
    output swmf_state_t                          state
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    swmf_state_t      state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] n_last;

    assign n_last = IDX_W'(fill - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ctl        = '0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_SCAN;
                    i_next     = '0;
                    j_next     = '0;
                end
            end
            S_SCAN:
            begin
                ctl.issue = 1'b1;
                ctl.first = (j_reg == '0);
                ctl.last  = (j_reg == n_last);
                if (j_reg == n_last)
                begin
                    j_next = '0;
                    if (i_reg == n_last)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                // last compare still in the rank unit
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cand_off = i_reg;
    assign elem_off = j_reg;
    assign state    = state_reg;

endmodule
`default_nettype wire

@@ rtl/sliding_window_median_filter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Running median filter over the most recent signed 16-bit samples.
//
// Input stream (s_*): one sample per item in s_tdata. Output stream (m_*): one
// median per input item, in order. window_size is set over the APB port at
// address 0 (0 acts as 1, values above WINDOW_MAX saturate); write it only while
// the block is idle.
//
// Each item is appended to a circular history; the oldest samples beyond the
// window are dropped, then a single shared comparator ranks every held sample
// against every held sample, itself included, one pair per cycle. With n held
// the sequencer scans all n*n pairs, passes a drain step for the last compare,
// then in the emit step loads the median into the output register once that is
// free; only then is the next item taken, so throughput is set by the pair
// count through the one compare unit. s_tready is high only while idle.
//
// Reset empties the history and sets window_size to 3. A stalled receiver
// holds m_tvalid and m_tdata; the block may take a new item meanwhile but
// holds its next result until the output register frees.
module sliding_window_median_filter_core
    import swmf_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // s_tdata: [15:0] sample
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [DATA_W-1:0]       s_tdata,
    // m_tdata: [15:0] median
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [DATA_W-1:0]            m_tdata,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic [CFG_W-1:0]  window_size_reg, window_size_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic              in_accept;
    logic              cfg_write;
    logic [CNT_W-1:0]  w_eff;
    logic [CNT_W-1:0]  fill;
    logic              out_free;
    logic              load_out;
    swmf_ctl_t         ctl;
    swmf_state_t       state;
    logic [IDX_W-1:0]  cand_off;
    logic [IDX_W-1:0]  elem_off;
    logic signed [DATA_W-1:0] cand;
    logic signed [DATA_W-1:0] elem;
    logic signed [DATA_W-1:0] median;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
    assign prdata    = (paddr[2] == REG_WINDOW_SIZE) ? APB_DATA_W'(window_size_reg) : '0;

    assign window_size_next = cfg_write ? pwdata[CFG_W-1:0] : window_size_reg;

    always_comb
    begin
        priority if (window_size_reg == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (32'(window_size_reg) > WINDOW_MAX)
        begin
            w_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            w_eff = CNT_W'(window_size_reg);
        end
    end

    assign s_tready  = (state == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tdata_next  = load_out ? median : m_tdata_reg;
    assign m_tvalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            window_size_reg <= window_size_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    swmf_hist #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (in_accept),
        .wr_data   (s_tdata),
        .win       (w_eff),
        .rd_a_off  (cand_off),
        .rd_b_off  (elem_off),
        .rd_a_data (cand),
        .rd_b_data (elem),
        .fill      (fill)
    );

    swmf_ctrl #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .fill      (fill),
        .out_free  (out_free),
        .ctl       (ctl),
        .cand_off  (cand_off),
        .elem_off  (elem_off),
        .load_out  (load_out),
        .state     (state)
    );

    swmf_rank #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_rank (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cand   (cand),
        .elem   (elem),
        .fill   (fill),
        .median (median)
    );

    // While busy the history holds at least one sample and never more than the window
    a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state != S_IDLE) |-> ((fill != '0) && (fill <= w_eff)))
        else $error("history count outside window while busy");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state == S_SCAN))
        else $error("accepted item did not start a scan");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state == S_EMIT))
        else $error("result presented outside the emit step");

endmodule
`default_nettype wire

@@ dv/swmf_median_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the sliding window median filter: tracks window_size writes on
// the APB port, predicts the median for every accepted sample, checks m_tdata.
// Depends on swmf_pkg for widths and the register index.
module swmf_median_checker
    import swmf_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [DATA_W-1:0]     m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatch_count,
    output int                    medians_pending
);

    logic signed [DATA_W-1:0] history [WINDOW_MAX];
    int                       oldest;
    int                       held;
    logic [CFG_W-1:0]         window_reg;
    logic [DATA_W-1:0]        median_q [$];
    int                       errors = 0;

    function automatic logic [DATA_W-1:0] held_median();
        logic signed [DATA_W-1:0] sorted [WINDOW_MAX];
        logic signed [DATA_W-1:0] key;
        logic [DATA_W-1:0]        result;
        int                       j;
        int                       sum;
        result = '0;
        for (int i = 0; i < held; i++)
            sorted[i] = history[(oldest + i) % WINDOW_MAX];
        for (int i = 1; i < held; i++)
        begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        if (held % 2 == 1)
            result = sorted[held/2];
        else if (held > 0)
        begin
            // even count: mean of the two middle values, truncated toward zero
            sum = int'(sorted[held/2-1]) + int'(sorted[held/2]);
            result = DATA_W'(sum / 2);
        end
        return result;
    endfunction

    task automatic push_sample(input logic [DATA_W-1:0] sample);
        int win;
        win = int'(window_reg);
        if (win < 1)
            win = 1;
        if (win > WINDOW_MAX)
            win = WINDOW_MAX;
        if (held >= WINDOW_MAX)
        begin
            history[oldest] = sample;
            oldest = (oldest + 1) % WINDOW_MAX;
        end
        else
        begin
            history[(oldest + held) % WINDOW_MAX] = sample;
            held++;
        end
        // drop samples beyond a window that shrank
        while (held > win)
        begin
            oldest = (oldest + 1) % WINDOW_MAX;
            held--;
        end
        median_q.insert(median_q.size(), held_median());
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_MAX; i++)
                history[i] = '0;
            oldest = 0;
            held = 0;
            window_reg = WINDOW_SIZE_RESET;
            median_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_SIZE)
                window_reg = pwdata[CFG_W-1:0];
            // check results before queuing the item accepted at this same edge
            if (m_tvalid && m_tready)
            begin
                if (median_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected median %h", $realtime, m_tdata);
                end
                else
                begin
                    if (m_tdata !== median_q[0])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: median mismatch, expected %h actual %h",
                                     $realtime, median_q[0], m_tdata);
                    end
                    void'(median_q.pop_front());
                end
            end
            if (s_tvalid && s_tready)
                push_sample(s_tdata);
        end
        mismatch_count <= errors;
        medians_pending <= median_q.size();
    end

endmodule

@@ dv/sliding_window_median_filter_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the median filter testbench: clock, reset, sample and APB stimulus,
// output backpressure and verdict. Depends on swmf_pkg and swmf_median_checker.
module sliding_window_median_filter_core_tb
    import swmf_pkg::*;
;

    localparam int QUIET_LIMIT    = 5000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_ITEMS    = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DATA_W-1:0]     m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatch_count;
    int medians_pending;
    int quiet_cycles;
    bit idle_on;
    bit hold_req;
    bit hold_done;

    sliding_window_median_filter_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    swmf_median_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_count  (mismatch_count),
        .medians_pending (medians_pending)
    );

    initial
        clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [DATA_W-1:0] random_sample();
        logic [DATA_W-1:0] base;
        base = DATA_W'($urandom);
        case ($urandom_range(0, 7))
            0: return {base[DATA_W-1], {(DATA_W-1){~base[DATA_W-1]}}};
            1: return $urandom_range(0, 1) ? '0 : '1;
            // narrow spread so ties and duplicate medians show up
            2, 3: return DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
            default: return base;
        endcase
    endfunction

    task automatic send_sample(input logic [DATA_W-1:0] sample);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge clk); while (!s_tready);
    endtask

    // drop valid and wait until every queued median has come back
    task automatic drain_medians();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (medians_pending != 0);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(input int size);
        drain_medians();
        apb_write(APB_ADDR_W'(4 * REG_WINDOW_SIZE), APB_DATA_W'(size));
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("sliding_window_median_filter_core test failed");
            $finish;
        end
    end

    initial
    begin
        int windows [12];
        windows = '{16, 2, 16, 1, 17, 0, 8, 31, 4, 0, 5, 3};
        windows[9] = $urandom_range(0, 31);
        idle_on = 1'b0;
        hold_req = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window of three, extremes of the sample range
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        // write to an unmapped register: window must stay at three
        drain_medians();
        apb_write(APB_ADDR_W'(4), APB_DATA_W'(1));
        send_sample(16'd100);
        send_sample(-16'sd100);
        send_sample(16'd7);
        // even count: mean truncated toward zero, no overflow on the sum
        set_window(2);
        send_sample(-16'sd3);
        send_sample(16'd0);
        send_sample(16'h8000);
        send_sample(16'h8001);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        // zero acts as a window of one
        set_window(0);
        send_sample(16'd5);
        send_sample(-16'sd7);
        // oversized window saturates
        set_window(31);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'h00FF);
        send_sample(16'hFF00);
        send_sample(16'h0F0F);
        send_sample(16'hF0F0);
        send_sample(16'h3333);
        send_sample(16'hCCCC);

        // random phases: full history then shrink, grow back, extremes of window
        foreach (windows[p])
        begin
            set_window(windows[p]);
            idle_on = (p % 4 != 3) && (p < 10);
            if (p == 1)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(random_sample());
        end

        drain_medians();
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && medians_pending == 0)
            $display("sliding_window_median_filter_core test passed");
        else
            $display("sliding_window_median_filter_core test failed");
        $finish;
    end

endmodule
